// File: design/gcm_pkg.sv
// Shared types and constants for the glyph cluster map.
`default_nettype none
package gcm_pkg;
	localparam int MAX_TEXT   = 1024;
	localparam int GLYPH_BITS = 16;
	localparam int IDX_W      = 11;
	localparam int ADDR_W     = 11;
	localparam int FRAC_W     = 17;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_FINISH = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_FILL, ST_SENT_RD, ST_SENT_WR,
		ST_QREAD, ST_SCAN_DN, ST_SCAN_UP, ST_DIV, ST_OUT
	} gcm_state_t;

	typedef struct packed {
		logic load_item;   // capture input item
		logic decode;      // evaluate request checks
		logic fill_step;   // write one fill entry
		logic sent_rd;     // read last entry
		logic sent_wr;     // write sentinel
		logic q_rd;        // read query entry
		logic dn_step;
		logic up_step;
		logic div_start;
		logic div_step;
		logic set_out;
	} gcm_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       fill_go;   // decode found a fill range
		logic       fill_done;
		logic       q_oor;
		logic       dn_done;
		logic       up_done;
		logic       div_done;
		logic       out_busy;
		logic       sent_go;
	} gcm_stat_t;
endpackage
`default_nettype wire

// File: design/gcm_ctrl.sv
// Controller state machine for the glyph cluster map.
`default_nettype none
module gcm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gcm_pkg::gcm_stat_t stat,
	output gcm_pkg::gcm_cmd_t     cmd
);
	import gcm_pkg::*;
	gcm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				case (stat.req)
					REQ_LOAD:   state_d = stat.fill_go ? ST_FILL : ST_OUT;
					REQ_FINISH: state_d = stat.fill_go ? ST_FILL :
						(stat.sent_go ? ST_SENT_RD : ST_OUT);
					REQ_QUERY:  state_d = stat.q_oor ? ST_OUT : ST_QREAD;
					default:    state_d = ST_OUT;
				endcase
			end
			ST_FILL: if (stat.fill_done)
				state_d = (stat.req == REQ_FINISH) ? ST_SENT_RD : ST_OUT;
			ST_SENT_RD: state_d = ST_SENT_WR;
			ST_SENT_WR: state_d = ST_OUT;
			ST_QREAD:   state_d = ST_SCAN_DN;
			ST_SCAN_DN: if (stat.dn_done) state_d = ST_SCAN_UP;
			ST_SCAN_UP: if (stat.up_done) state_d = ST_DIV;
			ST_DIV:     if (stat.div_done) state_d = ST_OUT;
			ST_OUT:     if (!stat.out_busy) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				cmd.q_rd = (stat.req == REQ_QUERY) && !stat.q_oor;
			end
			ST_FILL:    cmd.fill_step = 1'b1;
			ST_SENT_RD: cmd.sent_rd = 1'b1;
			ST_SENT_WR: cmd.sent_wr = 1'b1;
			ST_QREAD:   cmd.dn_step = 1'b0;
			// hold the scans once they report done
			ST_SCAN_DN: cmd.dn_step = !stat.dn_done;
			ST_SCAN_UP: begin
				cmd.up_step = !stat.up_done;
				cmd.div_start = stat.up_done;
			end
			ST_DIV:     cmd.div_step = 1'b1;
			ST_OUT:     cmd.set_out = !stat.out_busy;
			default:    cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: design/gcm_dp.sv
// Datapath: cluster table memory, counters, scans and fraction divider.
`default_nettype none
module gcm_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gcm_pkg::gcm_cmd_t   cmd,
	output gcm_pkg::gcm_stat_t       stat,
	input  wire logic [1:0]          req_type,
	input  wire logic [10:0]         text_index,
	input  wire logic [10:0]         query_index,
	input  wire logic                invert,
	input  wire logic [10:0]         text_length,
	output logic                     m_valid,
	input  wire logic                m_ready,
	output logic [56:0]              m_data
);
	import gcm_pkg::*;

	logic [GLYPH_BITS-1:0] mem [0:MAX_TEXT];
	logic [GLYPH_BITS-1:0] rd_q;
	logic [GLYPH_BITS-1:0] val_q;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [GLYPH_BITS-1:0] wr_data;

	logic [1:0]  req_q;
	logic [10:0] t_q, q_q;
	logic        inv_q;
	logic [15:0] gc_q;
	logic [10:0] prev_q, size_q;
	logic [10:0] fend_q, fptr_q;
	logic        err_q;
	logic [10:0] start_q, end_q;
	logic        dn_pend_q, up_pend_q, dn_done_q, up_done_q;
	logic        bnd_q;
	logic [27:0] rem_q;
	logic [16:0] quo_q;
	logic [11:0] len_q;
	logic [4:0]  dcnt_q;
	logic [56:0] res_d;

	// decode checks
	logic load_bad, load_fill, fin_bad, fin_fill;
	always_comb begin
		load_bad = (t_q < prev_q) || (t_q > text_length) || (t_q > 11'(MAX_TEXT)) ||
			(gc_q == 16'd0 && t_q > prev_q) || (gc_q == 16'hFFFF);
		load_fill = !load_bad && (t_q > prev_q);
		fin_bad = (text_length > 11'(MAX_TEXT)) || (gc_q == 16'd0 && prev_q < text_length);
		fin_fill = !fin_bad && (prev_q < text_length);
	end

	always_comb begin
		stat.req = req_q;
		stat.fill_go = (req_q == REQ_LOAD) ? load_fill : fin_fill;
		stat.sent_go = !fin_bad;
		stat.fill_done = (fptr_q + 11'd1 == fend_q);
		stat.q_oor = (q_q >= size_q);
		stat.dn_done = dn_done_q;
		stat.up_done = up_done_q;
		stat.div_done = (dcnt_q == 5'd0);
		stat.out_busy = m_valid && !m_ready;
	end

	// memory port control
	logic [10:0] dn_addr, up_addr;
	logic        dn_adv, up_adv;
	assign dn_addr = start_q - 11'd1;
	assign up_addr = end_q + 11'd1;
	// on a match the scan moves, so fetch the entry one further out
	assign dn_adv = dn_pend_q && (rd_q == val_q);
	assign up_adv = up_pend_q && (rd_q == val_q);
	always_comb begin
		rd_en = 1'b0;
		rd_addr = q_q;
		if (cmd.q_rd) begin rd_en = 1'b1; rd_addr = q_q; end
		else if (cmd.sent_rd) begin rd_en = 1'b1; rd_addr = text_length - 11'd1; end
		else if (cmd.dn_step) begin
			rd_en = 1'b1;
			rd_addr = dn_adv ? start_q - 11'd2 : dn_addr;
		end else if (cmd.up_step) begin
			rd_en = 1'b1;
			rd_addr = up_adv ? end_q + 11'd2 : up_addr;
		end
		wr_en = cmd.fill_step || cmd.sent_wr;
		wr_addr = cmd.fill_step ? fptr_q : text_length;
		// a load has already advanced the counter at decode
		if (cmd.fill_step) wr_data = (req_q == REQ_LOAD) ? gc_q - 16'd2 : gc_q - 16'd1;
		else wr_data = (text_length == 11'd0) ? '0 : rd_q + 16'd1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_comb begin
		res_d = '0;
		res_d[0] = err_q;
		if (req_q == REQ_QUERY) begin
			if (err_q) begin
				res_d[38:28] = q_q;
				res_d[39] = 1'b1;
			end else begin
				res_d[16:1] = val_q;
				res_d[27:17] = end_q - q_q + 11'd1;
				res_d[38:28] = start_q;
				res_d[39] = bnd_q;
				res_d[56:40] = inv_q ? 17'h10000 - quo_q : quo_q;
			end
		end
	end

	logic [27:0] rem_sh;
	logic [27:0] len_ext;
	assign rem_sh = {rem_q[26:0], 1'b0};
	assign len_ext = {16'd0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q <= '0; prev_q <= '0; size_q <= '0;
			m_valid <= 1'b0; dn_pend_q <= 1'b0; up_pend_q <= 1'b0;
			dn_done_q <= 1'b0; up_done_q <= 1'b0; dcnt_q <= '0;
			req_q <= '0; t_q <= '0; q_q <= '0; inv_q <= 1'b0;
			fend_q <= '0; fptr_q <= '0; err_q <= 1'b0;
			start_q <= '0; end_q <= '0; bnd_q <= 1'b0; val_q <= '0;
			rem_q <= '0; quo_q <= '0; len_q <= '0; m_data <= '0;
		end else begin
			if (cmd.set_out) begin
				m_valid <= 1'b1;
				m_data <= res_d;
			end else if (m_valid && m_ready) begin
				m_valid <= 1'b0;
			end
			if (cmd.load_item) begin
				req_q <= req_type; t_q <= text_index; q_q <= query_index; inv_q <= invert;
				err_q <= 1'b0; bnd_q <= 1'b0; quo_q <= '0; start_q <= query_index;
				end_q <= query_index; dn_done_q <= 1'b0; up_done_q <= 1'b0;
			end
			if (cmd.decode) begin
				case (req_q)
					REQ_LOAD: begin
						err_q <= load_bad;
						fptr_q <= prev_q; fend_q <= t_q;
						if (!load_bad) begin prev_q <= t_q; gc_q <= gc_q + 16'd1; end
					end
					REQ_FINISH: begin
						err_q <= fin_bad;
						fptr_q <= prev_q; fend_q <= text_length;
						if (!fin_bad) size_q <= text_length + 11'd1;
					end
					REQ_QUERY: begin
						err_q <= (q_q >= size_q);
						dn_pend_q <= 1'b0;
						bnd_q <= 1'b1;
					end
					default: err_q <= 1'b0;
				endcase
			end
			if (cmd.fill_step) fptr_q <= fptr_q + 11'd1;
			if (cmd.sent_wr || (cmd.decode && req_q == REQ_FINISH && fin_bad)) begin
				gc_q <= '0; prev_q <= '0;
			end
			// scan down: rd_q holds entry at start-1 once pending
			if (cmd.dn_step) begin
				if (!dn_pend_q) begin
					val_q <= rd_q;
					if (start_q == 11'd0) dn_done_q <= 1'b1;
					else dn_pend_q <= 1'b1;
				end else if (rd_q == val_q) begin
					if (start_q == q_q) bnd_q <= 1'b0;
					start_q <= dn_addr;
					if (dn_addr == 11'd0) begin dn_done_q <= 1'b1; dn_pend_q <= 1'b0; end
				end else begin
					dn_done_q <= 1'b1; dn_pend_q <= 1'b0;
				end
			end
			if (cmd.up_step) begin
				if (!up_pend_q) begin
					if (up_addr >= size_q) up_done_q <= 1'b1;
					else up_pend_q <= 1'b1;
				end else if (rd_q == val_q) begin
					end_q <= up_addr;
					if (up_addr + 11'd1 >= size_q) begin
						up_done_q <= 1'b1; up_pend_q <= 1'b0;
					end
				end else begin
					up_done_q <= 1'b1; up_pend_q <= 1'b0;
				end
			end
			if (cmd.div_start) begin
				rem_q <= {1'b0, q_q - start_q, 16'd0};
				len_q <= {1'b0, end_q} - {1'b0, start_q} + 12'd1;
				quo_q <= '0;
				dcnt_q <= 5'd17;
			end else if (cmd.div_step && dcnt_q != 5'd0) begin
				// restoring division, one quotient bit per cycle, MSB first
				if (rem_q[27:16] >= len_q) begin
					rem_q <= rem_sh - {(len_ext << 17)};
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[15:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 5'd1;
			end
		end
	end
	// The divider tests rem[27:16] against len with rem pre-shifted; subtract aligned.
endmodule
`default_nettype wire

// File: design/glyph_cluster_map.sv
// Top level of the glyph cluster map.
//
// Input stream s_axis_*: tdata = text_index, query_index, invert; tuser = req_type.
// Output stream m_axis_*: one result per accepted item, held in an output
// register until taken. tdata = error, glyph_number, run_count,
// cluster_start, boundary, advance_fraction (from bit 0 up).
// APB register 0 (byte address 0) holds text_length.
// One item at a time. A load fills the entries up to its index;
// a good finish also writes the sentinel. An in-range query walks the
// cluster through the single table read port, then runs a 17-step
// shift-subtract divider; an out-of-range query goes straight to output.
// After reset the counters are clear and queries report out of range
// until a good finish. A stalled output holds its result; the block may
// take the next item meanwhile but holds its result until the first is taken.
`default_nettype none
module glyph_cluster_map (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // text_index, query_index, invert
	input  wire logic [1:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // error, glyph_number, run_count, cluster_start, boundary, advance_fraction
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import gcm_pkg::*;
	gcm_cmd_t    cmd;
	gcm_stat_t   stat;
	logic [10:0] text_length_q;
	logic [56:0] res;

	assign pready = 1'b1;
	assign prdata = paddr ? 32'd0 : {21'd0, text_length_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) text_length_q <= '0;
		else if (psel && penable && pwrite && !paddr) text_length_q <= pwdata[10:0];
	end

	gcm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.stat(stat), .cmd(cmd)
	);
	gcm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(s_axis_tuser), .text_index(s_axis_tdata[10:0]),
		.query_index(s_axis_tdata[21:11]), .invert(s_axis_tdata[22]),
		.text_length(text_length_q), .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.m_data(res)
	);
	assign m_axis_tdata = {7'd0, res};
endmodule
`default_nettype wire
